[sv/spmsfm_pkg.sv]
// ----------------------------------------------------------------------------
// spmsfm_pkg
// Shared types and constants of the scratchpad stack frame manager: address
// and count widths, operation and error codes, the frame table entry and the
// structures passed between the frame table logic and the top level.
// ----------------------------------------------------------------------------
package spmsfm_pkg;

	// Table depth and address width.
	localparam int MAX_FRAMES = 32;
	localparam int ADDR_WIDTH = 32;
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

	typedef logic [ADDR_WIDTH-1:0] addr_t;
	typedef logic [CNT_W-1:0]      count_t;
	typedef logic [IDX_W-1:0]      idx_t;

	// Register indexes of the configuration port.
	localparam logic REG_SCRATCH_BASE = 1'b0;
	localparam logic REG_MEMORY_BASE  = 1'b1;

	// Operation codes of an input beat.
	typedef enum logic [1:0] {
		OP_STORE = 2'd0,
		OP_LOAD  = 2'd1,
		OP_L2G   = 2'd2,
		OP_G2L   = 2'd3
	} op_t;

	// Error codes of a result beat.
	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2
	} err_t;

	// Copy directions.
	localparam logic DIR_TO_MEM     = 1'b0;
	localparam logic DIR_TO_SCRATCH = 1'b1;

	// One evicted frame as held in the frame table.
	typedef struct packed {
		addr_t scratch_addr;
		addr_t image_addr;
		addr_t size;
	} frame_entry_t;

	// Operands captured when an input beat is accepted.
	typedef struct packed {
		op_t   op;
		addr_t sp;
		addr_t addr;
		addr_t size;          // scratch base minus stack pointer
		addr_t sb_minus_addr; // scratch base minus address
		logic  in_local;      // address within [sp, scratch base)
		logic  below_mbase;   // address below memory stack base
		logic  empty;         // frame table empty
		logic  full;          // frame table full
	} op_ctx_t;

	// Fields of one result beat.
	typedef struct packed {
		addr_t translated_address;
		addr_t copy_memory_address;
		addr_t copy_length;
		logic  copy_request;
		logic  copy_direction;
		logic  evicted_hit;
		err_t  error_code;
	} result_t;

	// Table updates requested by the datapath.
	typedef struct packed {
		logic push;
		logic pop;
	} tbl_ctrl_t;

endpackage

[sv/spm_stack_frame_manager.sv]
// The result beat is registered from the operands captured on the input beat.
// A new input beat is taken only once the last one retires, as the newest
// frame is read on the input beat and a push is written to the table as the
// result registers. A stalled result holds the next beat in its execute cycle.
// Reset clears the frame count, both base registers and the output valid.
// ----------------------------------------------------------------------------
// spm_stack_frame_manager
// Scratchpad stack frame manager: keeps a table of evicted stack frames,
// issues frame copy requests on store and load, and translates addresses
// between the live scratchpad frame and its memory image.
// ----------------------------------------------------------------------------
module spm_stack_frame_manager (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_write_enable,
	input  logic        cfg_index,
	input  logic [31:0] cfg_write_data,
	// Input channel.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] stack_pointer,
	input  logic [31:0] address,
	// Output channel.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] translated_address,
	output logic [31:0] copy_memory_address,
	output logic [31:0] copy_length,
	output logic        copy_request,
	output logic        copy_direction,
	output logic        evicted_hit,
	output logic [1:0]  error_code
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t                   state_q;
	spmsfm_pkg::addr_t        scratch_base_q;
	spmsfm_pkg::addr_t        memory_base_q;
	spmsfm_pkg::count_t       count_q;
	spmsfm_pkg::op_ctx_t      ctx_s1;
	spmsfm_pkg::op_ctx_t      ctx_in;
	spmsfm_pkg::frame_entry_t newest;
	spmsfm_pkg::frame_entry_t wr_entry;
	spmsfm_pkg::result_t      res;
	spmsfm_pkg::result_t      res_q;
	spmsfm_pkg::tbl_ctrl_t    ctrl;
	spmsfm_pkg::idx_t         rd_addr;
	spmsfm_pkg::idx_t         wr_addr;
	logic                     in_beat;
	logic                     out_free;
	logic                     retire;
	logic                     out_valid_q;

	assign in_beat  = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign retire   = (state_q == ST_EXEC) && out_free;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scratch_base_q <= '0;
			memory_base_q  <= '0;
		end else if (cfg_write_enable) begin
			unique case (cfg_index)
				spmsfm_pkg::REG_SCRATCH_BASE:
					scratch_base_q <= spmsfm_pkg::addr_t'(cfg_write_data);
				spmsfm_pkg::REG_MEMORY_BASE:
					memory_base_q  <= spmsfm_pkg::addr_t'(cfg_write_data);
				default:          scratch_base_q <= scratch_base_q;
			endcase
		end
	end

	// Operand preparation on the input beat.
	always_comb begin
		ctx_in.op            = spmsfm_pkg::op_t'(operation);
		ctx_in.sp            = spmsfm_pkg::addr_t'(stack_pointer);
		ctx_in.addr          = spmsfm_pkg::addr_t'(address);
		ctx_in.size          = scratch_base_q - ctx_in.sp;
		ctx_in.sb_minus_addr = scratch_base_q - ctx_in.addr;
		ctx_in.in_local      = (ctx_in.addr >= ctx_in.sp) && (ctx_in.addr < scratch_base_q);
		ctx_in.below_mbase   = ctx_in.addr < memory_base_q;
		ctx_in.empty         = (count_q == '0);
		ctx_in.full          = (count_q >= spmsfm_pkg::CNT_W'(spmsfm_pkg::MAX_FRAMES));
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			ctx_s1 <= ctx_in;
		end
	end

	// Frame table: the newest entry is read on every input beat.
	assign rd_addr  = spmsfm_pkg::IDX_W'(count_q - spmsfm_pkg::CNT_W'(1));
	assign wr_addr  = spmsfm_pkg::IDX_W'(count_q);
	assign wr_entry = '{scratch_addr: ctx_s1.sp,
	                    image_addr:   res.copy_memory_address,
	                    size:         ctx_s1.size};

	spmsfm_frame_ram u_frame_ram (
		.clk     (clk),
		.wr_en   (retire && ctrl.push),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (in_beat),
		.rd_addr (rd_addr),
		.rd_data (newest)
	);

	spmsfm_xlate u_xlate (
		.ctx          (ctx_s1),
		.newest       (newest),
		.scratch_base (scratch_base_q),
		.memory_base  (memory_base_q),
		.res          (res),
		.ctrl         (ctrl)
	);

	// Sequencer and frame count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (retire) begin
						state_q <= ST_IDLE;
						if (ctrl.push) begin
							count_q <= count_q + spmsfm_pkg::CNT_W'(1);
						end else if (ctrl.pop) begin
							count_q <= count_q - spmsfm_pkg::CNT_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (retire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			res_q <= res;
		end
	end

	assign out_valid           = out_valid_q;
	assign translated_address  = 32'(res_q.translated_address);
	assign copy_memory_address = 32'(res_q.copy_memory_address);
	assign copy_length         = 32'(res_q.copy_length);
	assign copy_request        = res_q.copy_request;
	assign copy_direction      = res_q.copy_direction;
	assign evicted_hit         = res_q.evicted_hit;
	assign error_code          = res_q.error_code;

`ifndef SYNTHESIS
	// The frame count never passes the table depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spmsfm_pkg::CNT_W'(spmsfm_pkg::MAX_FRAMES))
		else $error("frame count above table depth");

	// The frame count moves only when an operation retires.
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> $past(retire))
		else $error("frame count changed outside retirement");

	// A copy request never comes with an error.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.copy_request) |-> (res_q.error_code == spmsfm_pkg::ERR_NONE))
		else $error("copy request with error code");

	// No new beat is taken while an operation is in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> !in_ready)
		else $error("input taken during execution");

	// The sequencer is always in exactly one state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");
`endif

endmodule

[sv/spmsfm_frame_ram.sv]
// ----------------------------------------------------------------------------
// spmsfm_frame_ram
// Frame table storage: one synchronous memory of frame entries with one write
// port and one registered read port. Contents are undefined until written.
// ----------------------------------------------------------------------------
module spmsfm_frame_ram (
	input  logic                      clk,
	input  logic                      wr_en,
	input  spmsfm_pkg::idx_t          wr_addr,
	input  spmsfm_pkg::frame_entry_t  wr_data,
	input  logic                      rd_en,
	input  spmsfm_pkg::idx_t          rd_addr,
	output spmsfm_pkg::frame_entry_t  rd_data
);

	spmsfm_pkg::frame_entry_t mem [spmsfm_pkg::MAX_FRAMES];
	spmsfm_pkg::frame_entry_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sv/spmsfm_xlate.sv]
// ----------------------------------------------------------------------------
// spmsfm_xlate
// Result datapath: combines the captured operands with the newest frame read
// from the table to form the result beat and the table update for one
// operation (frame store, frame load and the two address translations).
// ----------------------------------------------------------------------------
module spmsfm_xlate (
	input  spmsfm_pkg::op_ctx_t      ctx,
	input  spmsfm_pkg::frame_entry_t newest,
	input  spmsfm_pkg::addr_t        scratch_base,
	input  spmsfm_pkg::addr_t        memory_base,
	output spmsfm_pkg::result_t      res,
	output spmsfm_pkg::tbl_ctrl_t    ctrl
);

	spmsfm_pkg::addr_t image_top;
	spmsfm_pkg::addr_t image_low;
	spmsfm_pkg::addr_t top_minus_addr;
	logic              in_image;

	// Memory image of the live frame: it ends at the newest evicted image, or at the memory base when the table is empty.
	always_comb begin
		image_top      = ctx.empty ? memory_base : newest.image_addr;
		image_low      = image_top - ctx.size;
		top_minus_addr = image_top - ctx.addr;
		in_image       = (ctx.addr >= image_low) && (ctx.addr < image_top);
	end

	// Per operation result and table update.
	always_comb begin
		res      = '0;
		ctrl     = '0;
		unique case (ctx.op)
			spmsfm_pkg::OP_STORE: begin
				if (ctx.full) begin
					res.error_code = spmsfm_pkg::ERR_FULL;
				end else begin
					res.translated_address  = ctx.sp;
					res.copy_memory_address = image_low;
					res.copy_length         = ctx.size;
					res.copy_request        = 1'b1;
					res.copy_direction      = spmsfm_pkg::DIR_TO_MEM;
					ctrl.push               = 1'b1;
				end
			end
			spmsfm_pkg::OP_LOAD: begin
				if (ctx.empty) begin
					res.error_code = spmsfm_pkg::ERR_EMPTY;
				end else begin
					res.translated_address  = newest.scratch_addr;
					res.copy_memory_address = newest.image_addr;
					res.copy_length         = newest.size;
					res.copy_request        = 1'b1;
					res.copy_direction      = spmsfm_pkg::DIR_TO_SCRATCH;
					ctrl.pop                = 1'b1;
				end
			end
			spmsfm_pkg::OP_L2G: begin
				res.translated_address = ctx.in_local ? (image_top - ctx.sb_minus_addr)
				                                      : ctx.addr;
			end
			spmsfm_pkg::OP_G2L: begin
				res.translated_address = ctx.addr;
				if (in_image) begin
					res.translated_address = scratch_base - top_minus_addr;
				end else if (!ctx.empty && (ctx.addr >= image_top) && ctx.below_mbase) begin
					res.evicted_hit = 1'b1;
				end
			end
			default: begin
				res  = '0;
				ctrl = '0;
			end
		endcase
	end

endmodule

[dv/spmsfm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmsfm_checker
// Watches the configuration port and both channels of the stack frame
// manager. It keeps its own frame table, predicts one result beat for every
// input beat taken, and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module spmsfm_checker
	import spmsfm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_enable,
	input  logic        cfg_index,
	input  logic [31:0] cfg_write_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] stack_pointer,
	input  logic [31:0] address,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] translated_address,
	input  logic [31:0] copy_memory_address,
	input  logic [31:0] copy_length,
	input  logic        copy_request,
	input  logic        copy_direction,
	input  logic        evicted_hit,
	input  logic [1:0]  error_code,
	output int          mismatch_count,
	output int          results_outstanding
);

	// Shadow frame table and base registers.
	addr_t       saved_sp    [MAX_FRAMES];
	addr_t       saved_image [MAX_FRAMES];
	addr_t       saved_len   [MAX_FRAMES];
	int unsigned frames_held;
	addr_t       scratch_base;
	addr_t       memory_base;

	result_t     expected_results [$];
	int          fails       = 0;
	int          outstanding = 0;
	int          beats_seen  = 0;

	assign mismatch_count      = fails;
	assign results_outstanding = outstanding;

	// Memory address of the newest evicted frame, or the memory base when
	// nothing has been evicted yet.
	function automatic addr_t newest_image();
		return (frames_held == 0) ? memory_base : saved_image[frames_held-1];
	endfunction

	// Works out the result beat of one operation and updates the shadow table.
	function automatic result_t predict_frame_op(op_t op, addr_t sp, addr_t addr);
		result_t r;
		addr_t   top;
		addr_t   span;
		addr_t   low;
		r    = '0;
		top  = newest_image();
		span = scratch_base - sp;
		case (op)
			OP_STORE: begin
				if (frames_held >= MAX_FRAMES) begin
					r.error_code = ERR_FULL;
				end else begin
					saved_sp[frames_held]    = sp;
					saved_len[frames_held]   = span;
					saved_image[frames_held] = top - span;
					r.translated_address     = sp;
					r.copy_memory_address    = top - span;
					r.copy_length            = span;
					r.copy_request           = 1'b1;
					r.copy_direction         = DIR_TO_MEM;
					frames_held++;
				end
			end
			OP_LOAD: begin
				if (frames_held == 0) begin
					r.error_code = ERR_EMPTY;
				end else begin
					frames_held--;
					r.translated_address  = saved_sp[frames_held];
					r.copy_memory_address = saved_image[frames_held];
					r.copy_length         = saved_len[frames_held];
					r.copy_request        = 1'b1;
					r.copy_direction      = DIR_TO_SCRATCH;
				end
			end
			OP_L2G: begin
				r.translated_address = addr;
				if (addr >= sp && addr < scratch_base)
					r.translated_address = top - (scratch_base - addr);
			end
			default: begin
				// Global to local: the live frame's image lies just below the
				// newest image; above it, up to the memory base, are evicted frames.
				low = top - span;
				r.translated_address = addr;
				if (addr >= low && addr < top)
					r.translated_address = scratch_base - (top - addr);
				else if (frames_held > 0 && addr >= top && addr < memory_base)
					r.evicted_hit = 1'b1;
			end
		endcase
		return r;
	endfunction

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH beat %0d %s: got %h, expected %h", beats_seen, what, got, want);
		fails++;
	endtask

	// Tracks configuration writes, predicts on input beats, checks result beats.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			frames_held  = 0;
			scratch_base = '0;
			memory_base  = '0;
			expected_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg_write_enable) begin
				if (cfg_index == REG_SCRATCH_BASE)
					scratch_base = cfg_write_data;
				else if (cfg_index == REG_MEMORY_BASE)
					memory_base = cfg_write_data;
			end
			if (in_valid && in_ready)
				expected_results.push_back(
					predict_frame_op(op_t'(operation), stack_pointer, address));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("beat with nothing outstanding", translated_address, '0);
				end else begin
					want = expected_results.pop_front();
					if (translated_address !== want.translated_address)
						report_mismatch("translated_address", translated_address,
							want.translated_address);
					if (copy_memory_address !== want.copy_memory_address)
						report_mismatch("copy_memory_address", copy_memory_address,
							want.copy_memory_address);
					if (copy_length !== want.copy_length)
						report_mismatch("copy_length", copy_length, want.copy_length);
					if (copy_request !== want.copy_request)
						report_mismatch("copy_request", 32'(copy_request),
							32'(want.copy_request));
					if (copy_direction !== want.copy_direction)
						report_mismatch("copy_direction", 32'(copy_direction),
							32'(want.copy_direction));
					if (evicted_hit !== want.evicted_hit)
						report_mismatch("evicted_hit", 32'(evicted_hit), 32'(want.evicted_hit));
					if (error_code !== want.error_code)
						report_mismatch("error_code", 32'(error_code), 32'(want.error_code));
				end
				beats_seen++;
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the scratchpad stack frame manager. A directed
// sequence covers the empty table, wrapped frame sizes and every translation
// window, then random phases under several base settings fill the table to full,
// push, pop and translate with random gaps on both channels and one long stall.
// ----------------------------------------------------------------------------
module tb_top;
	import spmsfm_pkg::*;

	localparam int   CYCLE_LIMIT      = 100000;
	localparam int   LONG_HOLD        = 80;
	localparam int   HOLD_AT_BEAT     = 130;

	logic        clk;
	logic        arst_n;
	logic        cfg_write_enable;
	logic        cfg_index;
	logic [31:0] cfg_write_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [31:0] stack_pointer;
	logic [31:0] address;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] translated_address;
	logic [31:0] copy_memory_address;
	logic [31:0] copy_length;
	logic        copy_request;
	logic        copy_direction;
	logic        evicted_hit;
	logic [1:0]  error_code;
	int          mismatch_count;
	int          results_outstanding;

	// Bases as last programmed, used to aim stack pointers and addresses.
	logic [31:0] scratch_base;
	logic [31:0] memory_base;
	logic        quiet;
	int          cycle_count;

	spm_stack_frame_manager DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_write_enable    (cfg_write_enable),
		.cfg_index           (cfg_index),
		.cfg_write_data      (cfg_write_data),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.operation           (operation),
		.stack_pointer       (stack_pointer),
		.address             (address),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.translated_address  (translated_address),
		.copy_memory_address (copy_memory_address),
		.copy_length         (copy_length),
		.copy_request        (copy_request),
		.copy_direction      (copy_direction),
		.evicted_hit         (evicted_hit),
		.error_code          (error_code)
	);

	spmsfm_checker u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_write_enable    (cfg_write_enable),
		.cfg_index           (cfg_index),
		.cfg_write_data      (cfg_write_data),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.operation           (operation),
		.stack_pointer       (stack_pointer),
		.address             (address),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.translated_address  (translated_address),
		.copy_memory_address (copy_memory_address),
		.copy_length         (copy_length),
		.copy_request        (copy_request),
		.copy_direction      (copy_direction),
		.evicted_hit         (evicted_hit),
		.error_code          (error_code),
		.mismatch_count      (mismatch_count),
		.results_outstanding (results_outstanding)
	);

	// Clock.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Run limit.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Result side: a random hold-off before each beat, and one long stall so
	// that the block fills up and holds its input.
	initial begin
		int gap;
		int rx_beats;
		out_ready = 1'b0;
		rx_beats  = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 5);
			if (rx_beats == HOLD_AT_BEAT)
				gap = LONG_HOLD;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			rx_beats++;
		end
	end

	// Offers one input beat after a random gap and waits until it is taken.
	task automatic send_beat(op_t op, logic [31:0] sp, logic [31:0] addr);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		stack_pointer <= sp;
		address       <= addr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stops offering beats and waits until every predicted beat has arrived.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes both base registers; only called with the block idle.
	task automatic program_bases(logic [31:0] sbase, logic [31:0] mbase);
		cfg_write_enable <= 1'b1;
		cfg_index        <= REG_SCRATCH_BASE;
		cfg_write_data   <= sbase;
		@(posedge clk);
		cfg_index        <= REG_MEMORY_BASE;
		cfg_write_data   <= mbase;
		@(posedge clk);
		cfg_write_enable <= 1'b0;
		scratch_base = sbase;
		memory_base  = mbase;
	endtask

	function automatic op_t choose_op(int store_pct, int load_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < store_pct)
			return OP_STORE;
		if (roll < store_pct + load_pct)
			return OP_LOAD;
		return roll[0] ? OP_L2G : OP_G2L;
	endfunction

	// Mostly small frames just below the scratchpad base, some wrapped ones.
	function automatic logic [31:0] choose_sp();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return scratch_base - 32'($urandom_range(1, 1024));
		if (roll < 75)
			return scratch_base;
		if (roll < 80)
			return '0;
		if (roll < 85)
			return '1;
		return $urandom();
	endfunction

	// Aims translation addresses at the live frame, its image and the
	// evicted region, with window edges and plain random values besides.
	function automatic logic [31:0] choose_address(op_t op, logic [31:0] sp);
		int          roll;
		logic [31:0] span;
		roll = $urandom_range(0, 99);
		span = scratch_base - sp;
		if (op == OP_L2G) begin
			if (roll < 55 && span != 0)
				return sp + ($urandom() % span);
			if (roll < 65)
				return scratch_base;
			if (roll < 72)
				return sp - 1;
		end else if (op == OP_G2L) begin
			if (roll < 60)
				return memory_base - 32'($urandom_range(1, 40000));
			if (roll < 68)
				return memory_base;
		end
		if (roll >= 92)
			return roll[0] ? 32'h0 : 32'hFFFF_FFFF;
		return $urandom();
	endfunction

	// One random phase: new bases, then a run of beats with the given mix.
	task automatic run_phase(logic [31:0] sbase, logic [31:0] mbase, int beats,
			int store_pct, int load_pct, logic no_gaps);
		op_t         op;
		logic [31:0] sp;
		drain();
		program_bases(sbase, mbase);
		quiet = no_gaps;
		repeat (beats) begin
			op = choose_op(store_pct, load_pct);
			sp = choose_sp();
			send_beat(op, sp, choose_address(op, sp));
		end
		quiet = 1'b0;
	endtask

	// Main sequence.
	initial begin
		arst_n           = 1'b0;
		cfg_write_enable = 1'b0;
		cfg_index        = REG_SCRATCH_BASE;
		cfg_write_data   = '0;
		in_valid         = 1'b0;
		operation        = OP_STORE;
		stack_pointer    = '0;
		address          = '0;
		scratch_base     = '0;
		memory_base      = '0;
		quiet            = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, two frames, wrapped frame, windows and edges.
		program_bases(32'h0001_0000, 32'h8000_0000);
		send_beat(OP_LOAD,  32'h0000_FF00, 32'h1234_5678);
		send_beat(OP_L2G,   32'h0000_FF00, 32'h0000_FF80);
		send_beat(OP_L2G,   32'h0000_FF00, 32'h0001_0000);
		send_beat(OP_G2L,   32'h0000_FF00, 32'h7FFF_FFF0);
		send_beat(OP_STORE, 32'h0000_FF00, 32'hFFFF_FFFF);
		send_beat(OP_STORE, 32'h0000_FE00, 32'h0000_0000);
		send_beat(OP_L2G,   32'h0000_FD00, 32'h0000_FD00);
		send_beat(OP_L2G,   32'h0000_FD00, 32'h0000_FCFF);
		send_beat(OP_G2L,   32'h0000_FD00, 32'h7FFF_FCFF);
		send_beat(OP_G2L,   32'h0000_FD00, 32'h7FFF_FFF0);
		send_beat(OP_G2L,   32'h0000_FD00, 32'h8000_0000);
		send_beat(OP_G2L,   32'h0000_FD00, 32'hFFFF_FFFF);
		send_beat(OP_STORE, 32'hFFFF_FFFF, 32'h5555_5555);
		send_beat(OP_L2G,   32'h0000_0000, 32'h0000_0000);
		send_beat(OP_L2G,   32'h0000_0000, 32'hFFFF_FFFF);
		send_beat(OP_G2L,   32'hFFFF_FFFF, 32'hAAAA_AAAA);
		send_beat(OP_LOAD,  32'h0000_0000, 32'h0000_0000);
		send_beat(OP_LOAD,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(OP_LOAD,  32'h0000_0000, 32'h0000_0000);
		send_beat(OP_LOAD,  32'h0000_0000, 32'h0000_0000);
		send_beat(OP_STORE, 32'h0000_0000, 32'hFFFF_FFFF);

		// Random phases: fill to full, drain to empty, and mixed traffic.
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 100, 70, 10, 1'b0);
		run_phase(32'h0000_0000, 32'h0000_0000,  90, 15, 65, 1'b0);
		run_phase($urandom(),    $urandom(),     90, 40, 30, 1'b1);
		run_phase(32'h0004_0000, 32'h0002_0000,  90, 70, 10, 1'b0);
		run_phase($urandom(),    $urandom(),     90, 20, 60, 1'b0);
		run_phase(32'h1000_0000, 32'hF000_0000,  90, 35, 35, 1'b0);
		drain();
		repeat (10) @(posedge clk);

		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[files.f]
sv/spmsfm_pkg.sv
sv/spmsfm_frame_ram.sv
sv/spmsfm_xlate.sv
sv/spm_stack_frame_manager.sv
dv/spmsfm_checker.sv
dv/tb_top.sv
